>>> design/fcc_pkg.sv
// Shared types and constants for the circular convolution block.
package fcc_pkg;

  localparam int RES_W = 42;
  localparam int CFG_W = 11;

  typedef enum logic [1:0] {
    OP_WR_SIG = 2'd0,
    OP_WR_FIL = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_FFT_LEN = 2'd0,
    CFG_SIG_LEN = 2'd1,
    CFG_FIL_LEN = 2'd2
  } cfg_idx_t;

endpackage

>>> design/fcc_mac.sv
// Shared complex multiply-accumulate unit, one registered product per cycle.
module fcc_mac #(
  parameter int SW = 16
) (
  input  logic                             clk,
  input  logic                             clr,
  input  logic                             en,
  input  logic signed [SW-1:0]             ar,
  input  logic signed [SW-1:0]             ai,
  input  logic signed [SW-1:0]             br,
  input  logic signed [SW-1:0]             bi,
  output logic signed [fcc_pkg::RES_W-1:0] acc_re,
  output logic signed [fcc_pkg::RES_W-1:0] acc_im
);

  logic signed [2*SW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                   pv_r;
  logic signed [fcc_pkg::RES_W-1:0] acc_re_r, acc_im_r;

  always_ff @(posedge clk) begin
    p_rr_r <= ar * br;
    p_ii_r <= ai * bi;
    p_ri_r <= ar * bi;
    p_ir_r <= ai * br;
    pv_r   <= en;
    if (clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (pv_r) begin
      acc_re_r <= acc_re_r + fcc_pkg::RES_W'(p_rr_r) - fcc_pkg::RES_W'(p_ii_r);
      acc_im_r <= acc_im_r + fcc_pkg::RES_W'(p_ri_r) + fcc_pkg::RES_W'(p_ir_r);
    end
  end

  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;

endmodule

>>> design/fft_circular_convolution.sv
// Top level: loads, circular convolution by a shared complex MAC, read-back.
// Loads: one transaction per cycle; a read holds off the next (registered store read).
// A result waiting in the output register holds off the next transaction.
// Compute: result transaction at accept, then busy for fft_length N: per
// output entry N MAC issues, a drain, a store state and a clear state.
// Synchronous active-low reset clears control and loads config defaults.
module fft_circular_convolution #(
  parameter int MAX_FFT     = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [fcc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_op,
  input  logic [9:0]                        in_index,
  input  logic signed [SAMPLE_BITS-1:0]     in_value_re,
  input  logic signed [SAMPLE_BITS-1:0]     in_value_im,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_status,
  output logic signed [fcc_pkg::RES_W-1:0]  out_result_re,
  output logic signed [fcc_pkg::RES_W-1:0]  out_result_im
);

  localparam int AW = $clog2(MAX_FFT);
  localparam int SW = SAMPLE_BITS;
  localparam int RW = fcc_pkg::RES_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [fcc_pkg::CFG_W-1:0] fft_len_r, sig_len_r, fil_len_r;

  // Stores: memories, registered reads.
  logic [2*SW-1:0] sig_mem [MAX_FFT];
  logic [2*SW-1:0] fil_mem [MAX_FFT];
  logic [2*RW-1:0] res_mem [MAX_FFT];
  logic [2*SW-1:0] sig_q_r, fil_q_r;
  logic [2*RW-1:0] res_q_r;

  // Compute sequencer.
  logic [AW:0]   k_r, j_r;     // output index, tap index
  logic [AW:0]   n_r;
  logic [AW-1:0] mask_r;
  logic          rd_v_r;       // memory read valid -> MAC issue
  logic [2:0]    drain_r;
  logic          clr;
  logic signed [RW-1:0] acc_re, acc_im;

  // Output register.
  logic                 ov_r, ost_r;
  logic signed [RW-1:0] ore_r, oim_r;
  logic                 rd_pend_r; // read result waits on memory latency
  logic                 rd_rng_r;

  wire in_acc  = in_valid && in_ready;
  wire out_acc = out_valid && out_ready;
  wire in_rng  = (32'(in_index) < MAX_FFT);
  wire [AW-1:0] in_addr = AW'(in_index);

  wire [fcc_pkg::CFG_W:0] n_ext = {1'b0, fft_len_r};
  wire len_ok = (fft_len_r != '0) && ((fft_len_r & (fft_len_r - 1'b1)) == '0) &&
                (32'(fft_len_r) <= MAX_FFT) &&
                (fft_len_r >= sig_len_r) && (fft_len_r >= fil_len_r);

  assign in_ready = (state_r == S_IDLE) && !rd_pend_r && (!ov_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fft_len_r <= fcc_pkg::CFG_W'(1024);
      sig_len_r <= fcc_pkg::CFG_W'(512);
      fil_len_r <= fcc_pkg::CFG_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcc_pkg::CFG_FFT_LEN: fft_len_r <= cfg_data;
        fcc_pkg::CFG_SIG_LEN: sig_len_r <= cfg_data;
        fcc_pkg::CFG_FIL_LEN: fil_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tap address: filter index (k - j) mod n.
  wire [AW-1:0] tap_j = AW'(j_r);
  wire [AW-1:0] tap_m = AW'(k_r - j_r) & mask_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_rng && in_op == fcc_pkg::OP_WR_SIG)
      sig_mem[in_addr] <= {in_value_re[SW-1:0], in_value_im[SW-1:0]};
    if (in_acc && in_rng && in_op == fcc_pkg::OP_WR_FIL)
      fil_mem[in_addr] <= {in_value_re[SW-1:0], in_value_im[SW-1:0]};
    sig_q_r <= sig_mem[tap_j];
    fil_q_r <= fil_mem[tap_m];
  end

  wire res_we = (state_r == S_DONE);
  always_ff @(posedge clk) begin
    if (res_we) res_mem[AW'(k_r)] <= {acc_re, acc_im};
    res_q_r <= res_mem[in_addr];
  end

  // Read data from the stores is registered; the MAC registers products the
  // next cycle and accumulates them the cycle after.
  fcc_mac #(.SW(SW)) u_mac (
    .clk(clk), .clr(clr), .en(rd_v_r),
    .ar(signed'(sig_q_r[2*SW-1:SW])), .ai(signed'(sig_q_r[SW-1:0])),
    .br(signed'(fil_q_r[2*SW-1:SW])), .bi(signed'(fil_q_r[SW-1:0])),
    .acc_re(acc_re), .acc_im(acc_im)
  );

  wire issue = (state_r == S_RUN) && (j_r < n_r);
  assign clr = (state_r == S_IDLE) || (state_r == S_READ);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && in_op == fcc_pkg::OP_COMPUTE && len_ok) state_nxt = S_RUN;
      S_RUN:  if (!issue && drain_r == '0) state_nxt = S_DONE;
      S_DONE: state_nxt = (k_r + 1'b1 == n_r) ? S_IDLE : S_READ;
      S_READ: state_nxt = S_RUN;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      k_r       <= '0;
      j_r       <= '0;
      rd_v_r    <= 1'b0;
      drain_r   <= '0;
      ov_r      <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      unique case (state_r)
        S_IDLE: begin
          k_r     <= '0;
          j_r     <= '0;
          drain_r <= '0;
          n_r     <= (AW+1)'(n_ext);
          mask_r  <= AW'(fft_len_r - 1'b1);
        end
        S_RUN: begin
          if (issue) begin
            j_r     <= j_r + 1'b1;
            drain_r <= 3'd4;
          end else if (drain_r != '0) begin
            drain_r <= drain_r - 1'b1;
          end
        end
        S_DONE: begin
          k_r <= k_r + 1'b1;
          j_r <= '0;
        end
        S_READ: drain_r <= '0;
        default: ;
      endcase
      // Result register.
      rd_pend_r <= in_acc && (in_op == fcc_pkg::OP_READ);
      if (in_acc) begin
        if (in_op == fcc_pkg::OP_READ) begin
          ost_r <= 1'b0;
        end else begin
          ost_r <= (in_op == fcc_pkg::OP_COMPUTE) && !len_ok;
          ore_r <= '0;
          oim_r <= '0;
        end
        rd_rng_r <= in_rng;
      end
      if (rd_pend_r) begin
        ore_r <= rd_rng_r ? signed'(res_q_r[2*RW-1:RW]) : '0;
        oim_r <= rd_rng_r ? signed'(res_q_r[RW-1:0]) : '0;
      end
      if (rd_pend_r || (in_acc && in_op != fcc_pkg::OP_READ)) ov_r <= 1'b1;
      else if (out_acc) ov_r <= 1'b0;
    end
  end

  assign out_valid     = ov_r;
  assign out_status    = ost_r;
  assign out_result_re = ore_r;
  assign out_result_im = oim_r;

endmodule

>>> design/fcc_checker.sv
// Port-level checker for the circular convolution block, bound to the top.
module fcc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_status,
  input logic [41:0] out_result_re
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_re))
    else $error("result dropped while stalled");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("accepted with full output");
  a_err0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_result_re == '0)
    else $error("error result carries data");
  a_rst: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("valid after reset");
endmodule

bind fft_circular_convolution fcc_checker u_fcc_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_result_re(out_result_re)
);
